// ===== rtl/sfh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types, codes and helpers for the framed spi host with ready line.
// ----------------------------------------------------------------------------
package sfh_pkg;

  // frame sizing
  localparam int MAX_PAYLOAD    = 128;
  localparam int HEADER_BYTES   = 8;
  localparam int TX_STORE_DEPTH = 128;
  localparam int TX_ADDR_W      = $clog2(TX_STORE_DEPTH);

  // header bytes
  localparam logic [7:0]  HDR_MAGIC_LO = 8'hAA;
  localparam logic [7:0]  HDR_MAGIC_HI = 8'h55;
  localparam logic [7:0]  PAD_BYTE     = 8'h00;
  localparam logic [15:0] PEER_MAGIC   = 16'h55AA;

  // configuration register indexes
  localparam logic [1:0] CFG_ASSERT_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_DEASSERT_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_RX_CAPACITY      = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] ASSERT_TIMEOUT_RST   = 16'd500;
  localparam logic [15:0] DEASSERT_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  RX_CAPACITY_RST      = 8'd80;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_XCHG  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ASSERT   = 3'd1,
    PH_XFER1    = 3'd2,
    PH_XFER2    = 3'd3,
    PH_DEASSERT = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE             = 3'd0,
    ST_OK               = 3'd1,
    ST_TOO_LONG         = 3'd2,
    ST_ASSERT_TIMEOUT   = 3'd3,
    ST_BAD_HEADER       = 3'd4,
    ST_XFER_FAILED      = 3'd5,
    ST_DEASSERT_TIMEOUT = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] tx_index;
    logic [7:0] tx_byte;
    logic [7:0] tx_length;
    logic       ready_level;
    logic [7:0] miso_byte;
    logic       spi_fault;
  } item_t;

  typedef struct packed {
    logic [15:0] assert_timeout_ticks;
    logic [15:0] deassert_timeout_ticks;
    logic [7:0]  rx_capacity;
  } cfg_t;

  typedef struct packed {
    logic        chip_select;
    logic        mosi_valid;
    logic        mosi_from_store;
    logic [7:0]  mosi_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        done_res;
    status_t     status;
    logic [15:0] rx_length;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [TX_ADDR_W-1:0] addr;
    logic [7:0]           data;
  } mem_wr_t;

  typedef struct packed {
    logic                 en;
    logic [TX_ADDR_W-1:0] addr;
  } mem_rd_t;

  // round up to a whole 4-byte word
  function automatic logic [16:0] pad4(input logic [15:0] n);
    pad4 = ({1'b0, n} + 17'd3) & ~17'd3;
  endfunction

endpackage

// ===== rtl/sfh_if.sv =====
// ----------------------------------------------------------------------------
// sfh_if
// Valid/ready channels of the spi frame host: request, result and config.
// ----------------------------------------------------------------------------
interface sfh_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] tx_index;
  logic [7:0] tx_byte;
  logic [7:0] tx_length;
  logic       ready_level;
  logic [7:0] miso_byte;
  logic       spi_fault;

  modport source (output valid, output opcode, output tx_index, output tx_byte,
                  output tx_length, output ready_level, output miso_byte,
                  output spi_fault, input ready);
  modport sink (input valid, input opcode, input tx_index, input tx_byte,
                input tx_length, input ready_level, input miso_byte,
                input spi_fault, output ready);
endinterface

interface sfh_rsp_if;
  logic        valid;
  logic        ready;
  logic        chip_select;
  logic        mosi_valid;
  logic [7:0]  mosi_byte;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        done_res;
  logic [2:0]  status;
  logic [15:0] rx_length;

  modport source (output valid, output chip_select, output mosi_valid,
                  output mosi_byte, output rx_valid, output rx_byte,
                  output done_res, output status, output rx_length, input ready);
  modport sink (input valid, input chip_select, input mosi_valid,
                input mosi_byte, input rx_valid, input rx_byte,
                input done_res, input status, input rx_length, output ready);
endinterface

interface sfh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sfh_tx_store.sv =====
// ----------------------------------------------------------------------------
// sfh_tx_store
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfh_tx_store (
  input  logic             clk,
  input  sfh_pkg::mem_wr_t wr,
  input  sfh_pkg::mem_rd_t rd,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [sfh_pkg::TX_STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== rtl/sfh_core.sv =====
// ----------------------------------------------------------------------------
// sfh_core
// Frame sequencer: phase, byte position, wait counter and peer header state,
// with the result of each item worked out in one pass.
// ----------------------------------------------------------------------------
module sfh_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sfh_pkg::item_t    item,
  input  sfh_pkg::cfg_t     cfg,
  output sfh_pkg::result_t  res,
  output sfh_pkg::mem_wr_t  mem_wr,
  output sfh_pkg::mem_rd_t  mem_rd
);

  sfh_pkg::phase_t phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] wait_ticks, wait_ticks_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [15:0] peer_magic, peer_magic_next;
  logic [15:0] peer_length, peer_length_next;
  logic        header_error, header_error_next;

  // derived frame sizes
  logic [16:0] pad_frame_full;
  logic [8:0]  pad_frame;
  logic [8:0]  first_len;
  logic [15:0] first_part;
  logic [15:0] remaining;
  logic [16:0] pad_remaining;
  logic [8:0]  pos_inc;
  logic        too_long;
  logic [15:0] peer_length_hdr;
  logic [7:0]  store_offset;

  assign pad_frame_full = sfh_pkg::pad4({8'b0, frame_length});
  assign pad_frame     = pad_frame_full[8:0];
  assign first_len     = 9'(sfh_pkg::HEADER_BYTES) + pad_frame;
  assign first_part    = (peer_length < {7'b0, pad_frame}) ? peer_length : {7'b0, pad_frame};
  assign remaining     = peer_length - first_part;
  assign pad_remaining = sfh_pkg::pad4(remaining);
  assign pos_inc       = {1'b0, byte_position} + 9'd1;
  assign too_long      = ({1'b0, item.tx_length} > 9'(sfh_pkg::MAX_PAYLOAD)) ||
                         (sfh_pkg::pad4({8'b0, item.tx_length}) >
                          17'(sfh_pkg::MAX_PAYLOAD));
  assign peer_length_hdr = {item.miso_byte, peer_length[7:0]};
  assign store_offset  = byte_position_next - 8'(sfh_pkg::HEADER_BYTES);

  // store access
  always_comb begin
    mem_wr.en   = accept && (sfh_pkg::op_t'(item.opcode) == sfh_pkg::OP_LOAD) &&
                  (phase == sfh_pkg::PH_IDLE);
    mem_wr.addr = item.tx_index;
    mem_wr.data = item.tx_byte;
    mem_rd.en   = accept;
    mem_rd.addr = store_offset[sfh_pkg::TX_ADDR_W-1:0];
  end

  // next state and result of one item
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    wait_ticks_next    = wait_ticks;
    frame_length_next  = frame_length;
    peer_magic_next    = peer_magic;
    peer_length_next   = peer_length;
    header_error_next  = header_error;
    res                = '0;
    res.status         = sfh_pkg::ST_NONE;

    case (sfh_pkg::op_t'(item.opcode))
      sfh_pkg::OP_LOAD: begin
        // store write only, handled by the store port
      end
      sfh_pkg::OP_START: begin
        if (phase == sfh_pkg::PH_IDLE) begin
          if (too_long) begin
            res.done_res = 1'b1;
            res.status   = sfh_pkg::ST_TOO_LONG;
          end else begin
            frame_length_next  = item.tx_length;
            byte_position_next = '0;
            wait_ticks_next    = '0;
            peer_magic_next    = '0;
            peer_length_next   = '0;
            header_error_next  = 1'b0;
            phase_next         = sfh_pkg::PH_ASSERT;
          end
        end
      end
      sfh_pkg::OP_TICK: begin
        if (phase == sfh_pkg::PH_ASSERT) begin
          if (item.ready_level) begin
            phase_next         = sfh_pkg::PH_XFER1;
            byte_position_next = '0;
          end else if (wait_ticks >= cfg.assert_timeout_ticks) begin
            phase_next   = sfh_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sfh_pkg::ST_ASSERT_TIMEOUT;
          end else begin
            wait_ticks_next = wait_ticks + 16'd1;
          end
        end else if (phase == sfh_pkg::PH_DEASSERT) begin
          if (!item.ready_level) begin
            phase_next   = sfh_pkg::PH_IDLE;
            res.done_res = 1'b1;
            if (header_error) begin
              res.status = sfh_pkg::ST_BAD_HEADER;
            end else begin
              res.status    = sfh_pkg::ST_OK;
              res.rx_length = peer_length;
            end
          end else if (wait_ticks >= cfg.deassert_timeout_ticks) begin
            phase_next   = sfh_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status   = header_error ? sfh_pkg::ST_BAD_HEADER
                                        : sfh_pkg::ST_DEASSERT_TIMEOUT;
          end else begin
            wait_ticks_next = wait_ticks + 16'd1;
          end
        end
      end
      sfh_pkg::OP_XCHG: begin
        if (((phase == sfh_pkg::PH_XFER1) || (phase == sfh_pkg::PH_XFER2)) &&
            item.spi_fault) begin
          phase_next   = sfh_pkg::PH_IDLE;
          res.done_res = 1'b1;
          res.status   = sfh_pkg::ST_XFER_FAILED;
        end else if (phase == sfh_pkg::PH_XFER1) begin
          // peer header capture, then payload bytes of the first transfer
          case (byte_position)
            8'd0: peer_magic_next = {8'b0, item.miso_byte};
            8'd1: peer_magic_next = {item.miso_byte, peer_magic[7:0]};
            8'd2: peer_length_next = {8'b0, item.miso_byte};
            8'd3: begin
              peer_length_next  = peer_length_hdr;
              header_error_next = (peer_magic != sfh_pkg::PEER_MAGIC) ||
                                  (peer_length_hdr > {8'b0, cfg.rx_capacity});
            end
            default: begin
              if ((byte_position >= 8'(sfh_pkg::HEADER_BYTES)) && !header_error &&
                  (({8'b0, byte_position} - 16'(sfh_pkg::HEADER_BYTES)) < first_part)) begin
                res.rx_valid = 1'b1;
                res.rx_byte  = item.miso_byte;
              end
            end
          endcase
          if (pos_inc >= first_len) begin
            byte_position_next = '0;
            wait_ticks_next    = '0;
            if (!header_error && (peer_length > first_part)) begin
              phase_next = sfh_pkg::PH_XFER2;
            end else begin
              phase_next = sfh_pkg::PH_DEASSERT;
            end
          end else begin
            byte_position_next = pos_inc[7:0];
          end
        end else if (phase == sfh_pkg::PH_XFER2) begin
          // rest of the peer payload, zeros sent
          if ({8'b0, byte_position} < remaining) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = item.miso_byte;
          end
          if ({8'b0, pos_inc} >= pad_remaining) begin
            byte_position_next = '0;
            wait_ticks_next    = '0;
            phase_next         = sfh_pkg::PH_DEASSERT;
          end else begin
            byte_position_next = pos_inc[7:0];
          end
        end
      end
      default: begin
      end
    endcase

    // line levels and next byte to shift
    res.chip_select = (phase_next != sfh_pkg::PH_IDLE);
    if (phase_next == sfh_pkg::PH_XFER1) begin
      res.mosi_valid = 1'b1;
      case (byte_position_next)
        8'd0:    res.mosi_byte = sfh_pkg::HDR_MAGIC_LO;
        8'd1:    res.mosi_byte = sfh_pkg::HDR_MAGIC_HI;
        8'd2:    res.mosi_byte = frame_length_next;
        default: res.mosi_byte = sfh_pkg::PAD_BYTE;
      endcase
      res.mosi_from_store = (byte_position_next >= 8'(sfh_pkg::HEADER_BYTES)) &&
                            (store_offset < frame_length_next);
    end else if (phase_next == sfh_pkg::PH_XFER2) begin
      res.mosi_valid = 1'b1;
      res.mosi_byte  = sfh_pkg::PAD_BYTE;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfh_pkg::PH_IDLE;
      byte_position <= '0;
      wait_ticks    <= '0;
      frame_length  <= '0;
      peer_magic    <= '0;
      peer_length   <= '0;
      header_error  <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      wait_ticks    <= wait_ticks_next;
      frame_length  <= frame_length_next;
      peer_magic    <= peer_magic_next;
      peer_length   <= peer_length_next;
      header_error  <= header_error_next;
    end
  end

endmodule

// ===== rtl/spi_frame_host_with_ready_handshake.sv =====
// ----------------------------------------------------------------------------
// spi_frame_host_with_ready_handshake
// Host side of a framed spi exchange paced by the peer ready line.
// ----------------------------------------------------------------------------
// One item is taken per clock and each item gives exactly one result, which
// shows in the output register on the cycle after the item is taken. The
// request channel stalls only while that register holds a result that the
// sink has not yet taken; a taken result frees it in the same cycle, so the
// rate stays one item per cycle. The payload store has 128 byte entries with
// one write and one registered read port; the read for the next byte to
// shift is issued on the same edge that updates the frame state. Store
// entries hold no value until loaded. Configuration writes are always ready.
module spi_frame_host_with_ready_handshake (
  input  logic      clk,
  input  logic      rst,
  sfh_req_if.sink   req,
  sfh_rsp_if.source rsp,
  sfh_cfg_if.sink   cfg
);

  sfh_pkg::cfg_t    cfg_regs;
  sfh_pkg::item_t   item;
  sfh_pkg::result_t res_next;
  sfh_pkg::result_t res;
  sfh_pkg::mem_wr_t mem_wr;
  sfh_pkg::mem_rd_t mem_rd;
  logic [7:0]       store_q;
  logic             out_valid;
  logic             accept;

  // request handshake
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_comb begin
    item.opcode      = req.opcode;
    item.tx_index    = req.tx_index;
    item.tx_byte     = req.tx_byte;
    item.tx_length   = req.tx_length;
    item.ready_level = req.ready_level;
    item.miso_byte   = req.miso_byte;
    item.spi_fault   = req.spi_fault;
  end

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.assert_timeout_ticks   <= sfh_pkg::ASSERT_TIMEOUT_RST;
      cfg_regs.deassert_timeout_ticks <= sfh_pkg::DEASSERT_TIMEOUT_RST;
      cfg_regs.rx_capacity            <= sfh_pkg::RX_CAPACITY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sfh_pkg::CFG_ASSERT_TIMEOUT:   cfg_regs.assert_timeout_ticks   <= cfg.data;
        sfh_pkg::CFG_DEASSERT_TIMEOUT: cfg_regs.deassert_timeout_ticks <= cfg.data;
        sfh_pkg::CFG_RX_CAPACITY:      cfg_regs.rx_capacity            <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // frame sequencer
  sfh_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg_regs),
    .res    (res_next),
    .mem_wr (mem_wr),
    .mem_rd (mem_rd)
  );

  // payload store
  sfh_tx_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (store_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // result channel
  assign rsp.valid       = out_valid;
  assign rsp.chip_select = res.chip_select;
  assign rsp.mosi_valid  = res.mosi_valid;
  assign rsp.mosi_byte   = res.mosi_from_store ? store_q : res.mosi_byte;
  assign rsp.rx_valid    = res.rx_valid;
  assign rsp.rx_byte     = res.rx_byte;
  assign rsp.done_res    = res.done_res;
  assign rsp.status      = res.status;
  assign rsp.rx_length   = res.rx_length;

endmodule

// ===== dv/tb_spi_frame_host_with_ready_handshake.sv =====
// ----------------------------------------------------------------------------
// tb_spi_frame_host_with_ready_handshake
// Self-checking bench for the framed spi host. A frame tracker mirrors the
// host state, predicts one result per accepted item and matches every
// result taken from the block. Stimulus is mostly whole frames with random
// peer content, mixed with stray and broken items, under several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spi_frame_host_with_ready_handshake;
  import sfh_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 450;

  typedef struct packed {
    logic        chip_select;
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] rx_length;
  } frame_res_t;

  // mirror of the host: frame state, payload store and due results
  class frame_tracker;
    logic [15:0] assert_to;
    logic [15:0] deassert_to;
    logic [7:0]  capacity;
    phase_t      phase;
    logic [7:0]  store [TX_STORE_DEPTH];
    bit          written [TX_STORE_DEPTH];
    int          byte_pos;
    logic [15:0] wait_ticks;
    logic [7:0]  frame_len;
    logic [15:0] peer_magic;
    logic [15:0] peer_len;
    bit          hdr_err;
    frame_res_t  due_results [$];
    int          errors;

    function new();
      assert_to   = ASSERT_TIMEOUT_RST;
      deassert_to = DEASSERT_TIMEOUT_RST;
      capacity    = RX_CAPACITY_RST;
      phase       = PH_IDLE;
      foreach (written[i]) begin
        written[i] = 1'b0;
        store[i]   = 8'h00;
      end
      byte_pos   = 0;
      wait_ticks = '0;
      frame_len  = '0;
      peer_magic = '0;
      peer_len   = '0;
      hdr_err    = 1'b0;
      errors     = 0;
    endfunction

    function int round_word(int n);
      return (n + 3) & ~3;
    endfunction

    // peer payload bytes that fit in the first transfer
    function int first_part();
      int p4;
      p4 = round_word(frame_len);
      return (peer_len < p4) ? int'(peer_len) : p4;
    endfunction

    function logic [7:0] tx_byte_at(int p);
      int d;
      case (p)
        0: return HDR_MAGIC_LO;
        1: return HDR_MAGIC_HI;
        2: return frame_len;
        3: return PAD_BYTE;
        default: ;
      endcase
      if (p < HEADER_BYTES) return PAD_BYTE;
      d = p - HEADER_BYTES;
      if (d < frame_len && d < TX_STORE_DEPTH) return store[d];
      return PAD_BYTE;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_ASSERT_TIMEOUT:   assert_to = val;
        CFG_DEASSERT_TIMEOUT: deassert_to = val;
        CFG_RX_CAPACITY:      capacity = val[7:0];
        default: ;
      endcase
    endfunction

    // advance the frame for one item; returns 1 unless the item is ignored
    function bit accept_item(item_t it);
      frame_res_t r;
      bit         used;
      int         p;
      int         rem;
      r = '0;
      used = 1'b0;
      case (it.opcode)
        OP_LOAD: begin
          if (phase == PH_IDLE) begin
            store[it.tx_index]   = it.tx_byte;
            written[it.tx_index] = 1'b1;
            used = 1'b1;
          end
        end
        OP_START: begin
          if (phase == PH_IDLE) begin
            used = 1'b1;
            if (it.tx_length > MAX_PAYLOAD || round_word(it.tx_length) > MAX_PAYLOAD) begin
              r.done_res = 1'b1;
              r.status   = ST_TOO_LONG;
            end else begin
              frame_len  = it.tx_length;
              byte_pos   = 0;
              wait_ticks = '0;
              peer_magic = '0;
              peer_len   = '0;
              hdr_err    = 1'b0;
              phase      = PH_ASSERT;
            end
          end
        end
        OP_TICK: begin
          if (phase == PH_ASSERT) begin
            used = 1'b1;
            if (it.ready_level) begin
              phase    = PH_XFER1;
              byte_pos = 0;
            end else if (wait_ticks >= assert_to) begin
              phase      = PH_IDLE;
              r.done_res = 1'b1;
              r.status   = ST_ASSERT_TIMEOUT;
            end else begin
              wait_ticks++;
            end
          end else if (phase == PH_DEASSERT) begin
            used = 1'b1;
            if (!it.ready_level) begin
              phase      = PH_IDLE;
              r.done_res = 1'b1;
              if (hdr_err) begin
                r.status = ST_BAD_HEADER;
              end else begin
                r.status    = ST_OK;
                r.rx_length = peer_len;
              end
            end else if (wait_ticks >= deassert_to) begin
              phase      = PH_IDLE;
              r.done_res = 1'b1;
              r.status   = hdr_err ? ST_BAD_HEADER : ST_DEASSERT_TIMEOUT;
            end else begin
              wait_ticks++;
            end
          end
        end
        default: begin
          if ((phase == PH_XFER1 || phase == PH_XFER2) && it.spi_fault) begin
            used       = 1'b1;
            phase      = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = ST_XFER_FAILED;
          end else if (phase == PH_XFER1) begin
            used = 1'b1;
            p = byte_pos;
            case (p)
              0: peer_magic = {8'h00, it.miso_byte};
              1: peer_magic = peer_magic | {it.miso_byte, 8'h00};
              2: peer_len = {8'h00, it.miso_byte};
              3: begin
                peer_len = peer_len | {it.miso_byte, 8'h00};
                hdr_err  = (peer_magic != PEER_MAGIC) || (peer_len > {8'h00, capacity});
              end
              default: begin
                if (p >= HEADER_BYTES && !hdr_err && p - HEADER_BYTES < first_part()) begin
                  r.rx_valid = 1'b1;
                  r.rx_byte  = it.miso_byte;
                end
              end
            endcase
            byte_pos = p + 1;
            if (byte_pos >= HEADER_BYTES + round_word(frame_len)) begin
              byte_pos   = 0;
              wait_ticks = '0;
              if (!hdr_err && peer_len > first_part()) phase = PH_XFER2;
              else phase = PH_DEASSERT;
            end
          end else if (phase == PH_XFER2) begin
            used = 1'b1;
            rem = int'(peer_len) - first_part();
            if (byte_pos < rem) begin
              r.rx_valid = 1'b1;
              r.rx_byte  = it.miso_byte;
            end
            byte_pos++;
            if (byte_pos >= round_word(rem)) begin
              byte_pos   = 0;
              wait_ticks = '0;
              phase      = PH_DEASSERT;
            end
          end
        end
      endcase

      // output levels after the update
      r.chip_select = (phase != PH_IDLE);
      if (phase == PH_XFER1) begin
        r.mosi_valid = 1'b1;
        r.mosi_byte  = tx_byte_at(byte_pos);
      end else if (phase == PH_XFER2) begin
        r.mosi_valid = 1'b1;
        r.mosi_byte  = PAD_BYTE;
      end
      due_results.push_back(r);
      return used;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void compare_result(frame_res_t got);
      frame_res_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing due: %p", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("chip_select", want.chip_select, got.chip_select);
      check_field("mosi_valid", want.mosi_valid, got.mosi_valid);
      check_field("mosi_byte", want.mosi_byte, got.mosi_byte);
      check_field("rx_valid", want.rx_valid, got.rx_valid);
      check_field("rx_byte", want.rx_byte, got.rx_byte);
      check_field("done_res", want.done_res, got.done_res);
      check_field("status", want.status, got.status);
      check_field("rx_length", want.rx_length, got.rx_length);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_req;
  int   stall_cycles;
  int   burst_left;
  int   useful_items;

  frame_tracker tracker = new();

  sfh_req_if req_ch ();
  sfh_rsp_if rsp_ch ();
  sfh_cfg_if cfg_ch ();

  spi_frame_host_with_ready_handshake u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: own stall pattern plus one long hold on request
  initial begin : rsp_side
    int mode;
    int left;
    int ph;
    bit rdy;
    mode = 0;
    left = 0;
    ph = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 48);
        end
        left--;
        ph++;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = (ph % 5 != 0) && (ph % 7 != 3);
          default: rdy = 1'($urandom_range(0, 1));
        endcase
        rsp_ch.ready <= rdy;
      end
    end
  end

  // result monitor and stall counter
  always @(posedge clk) begin : rsp_mon
    frame_res_t got;
    got.chip_select = rsp_ch.chip_select;
    got.mosi_valid  = rsp_ch.mosi_valid;
    got.mosi_byte   = rsp_ch.mosi_byte;
    got.rx_valid    = rsp_ch.rx_valid;
    got.rx_byte     = rsp_ch.rx_byte;
    got.done_res    = rsp_ch.done_res;
    got.status      = rsp_ch.status;
    got.rx_length   = rsp_ch.rx_length;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) tracker.compare_result(got);
  end

  // watchdog
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic item_t rnd_item();
    item_t it;
    it.opcode      = 2'($urandom_range(0, 3));
    it.tx_index    = 7'($urandom());
    it.tx_byte     = 8'($urandom());
    it.tx_length   = 8'($urandom());
    it.ready_level = 1'($urandom());
    it.miso_byte   = 8'($urandom());
    it.spi_fault   = 1'($urandom());
    return it;
  endfunction

  // offer one item in bursts with random gaps; returns at a falling edge
  task automatic push_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_ch.opcode      <= it.opcode;
    req_ch.tx_index    <= it.tx_index;
    req_ch.tx_byte     <= it.tx_byte;
    req_ch.tx_length   <= it.tx_length;
    req_ch.ready_level <= it.ready_level;
    req_ch.miso_byte   <= it.miso_byte;
    req_ch.spi_fault   <= it.spi_fault;
    req_ch.valid       <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (tracker.accept_item(it)) useful_items++;
    @(negedge clk);
  endtask

  task automatic do_load(input logic [6:0] idx, input logic [7:0] val);
    item_t it;
    it = rnd_item();
    it.opcode   = OP_LOAD;
    it.tx_index = idx;
    it.tx_byte  = val;
    push_item(it);
  endtask

  // a start never reads store entries that were never loaded
  task automatic do_start(input logic [7:0] len);
    item_t it;
    if (tracker.phase == PH_IDLE && len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++)
        if (!tracker.written[i]) do_load(7'(i), 8'($urandom()));
    end
    it = rnd_item();
    it.opcode    = OP_START;
    it.tx_length = len;
    push_item(it);
  endtask

  task automatic do_tick(input logic rdy);
    item_t it;
    it = rnd_item();
    it.opcode      = OP_TICK;
    it.ready_level = rdy;
    push_item(it);
  endtask

  task automatic do_xchg(input logic [7:0] miso, input logic fault);
    item_t it;
    it = rnd_item();
    it.opcode    = OP_XCHG;
    it.miso_byte = miso;
    it.spi_fault = fault;
    push_item(it);
  endtask

  // stop offering until every due result is in
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    @(negedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  // bring an open frame to its end by the shortest path
  task automatic close_frame();
    while (tracker.phase != PH_IDLE) begin
      case (tracker.phase)
        PH_ASSERT:   do_tick(1'b1);
        PH_DEASSERT: do_tick(1'b0);
        default:     do_xchg(8'($urandom()), 1'b1);
      endcase
    end
  endtask

  task automatic program_regs(input logic [15:0] a_to, input logic [15:0] d_to,
                              input logic [7:0] cap);
    close_frame();
    wait_drained();
    cfg_write(CFG_ASSERT_TIMEOUT, a_to);
    cfg_write(CFG_DEASSERT_TIMEOUT, d_to);
    cfg_write(CFG_RX_CAPACITY, {8'h00, cap});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(MAX_PAYLOAD + 1, 255);
    if (r <= 2) return $urandom_range(100, MAX_PAYLOAD);
    return $urandom_range(0, 20);
  endfunction

  // one frame with random peer content, mostly well formed
  task automatic run_frame(input int len);
    int          cap;
    int          r;
    int          a_to;
    int          d_to;
    int          wrong_a;
    int          wrong_d;
    int          sent_a;
    int          sent_d;
    bit          bad_magic;
    logic [15:0] plen;
    logic [7:0]  miso;
    item_t       it;
    cap = tracker.capacity;
    a_to = tracker.assert_to;
    d_to = tracker.deassert_to;
    bad_magic = 1'b0;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      bad_magic = 1'b1;
      plen = 16'($urandom_range(0, cap));
    end else if (r == 1) begin
      plen = 16'($urandom_range(cap + 1, cap + 40));
    end else if (r == 2) begin
      plen = 16'($urandom()) | 16'h0100;
    end else if (r < 11) begin
      plen = 16'($urandom_range(0, (cap < 12) ? cap : 12));
    end else begin
      plen = 16'($urandom_range(0, cap));
    end
    if (a_to <= 12 && $urandom_range(0, 4) == 0) wrong_a = a_to + 1;
    else wrong_a = $urandom_range(0, (a_to < 3) ? a_to : 3);
    if (d_to <= 12 && $urandom_range(0, 4) == 0) wrong_d = d_to + 1;
    else wrong_d = $urandom_range(0, (d_to < 3) ? d_to : 3);
    sent_a = 0;
    sent_d = 0;
    do_start(8'(len));
    while (tracker.phase != PH_IDLE) begin
      if ($urandom_range(0, 14) == 0) begin
        // stray item in the middle of the frame
        it = rnd_item();
        if (it.opcode == OP_XCHG) it.spi_fault = ($urandom_range(0, 7) == 0);
        push_item(it);
      end else begin
        case (tracker.phase)
          PH_ASSERT: begin
            if (sent_a < wrong_a) begin
              do_tick(1'b0);
              sent_a++;
            end else begin
              do_tick(1'b1);
            end
          end
          PH_XFER1: begin
            case (tracker.byte_pos)
              0: miso = bad_magic ? 8'($urandom()) : PEER_MAGIC[7:0];
              1: miso = PEER_MAGIC[15:8];
              2: miso = plen[7:0];
              3: miso = plen[15:8];
              default: miso = 8'($urandom());
            endcase
            do_xchg(miso, $urandom_range(0, 79) == 0);
          end
          PH_XFER2: do_xchg(8'($urandom()), $urandom_range(0, 79) == 0);
          default: begin
            if (sent_d < wrong_d) begin
              do_tick(1'b1);
              sent_d++;
            end else begin
              do_tick(1'b0);
            end
          end
        endcase
      end
    end
  endtask

  // random traffic until the running item count reaches a target
  task automatic random_traffic(input int target);
    item_t it;
    while (useful_items < target) begin
      if ($urandom_range(0, 4) == 0) begin
        it = rnd_item();
        if (it.opcode == OP_START) do_start(it.tx_length);
        else push_item(it);
      end else begin
        run_frame(pick_len());
      end
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    hold_req = 1'b0;
    burst_left = 0;
    useful_items = 0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOAD;
    req_ch.tx_index = '0;
    req_ch.tx_byte = '0;
    req_ch.tx_length = '0;
    req_ch.ready_level = 1'b0;
    req_ch.miso_byte = '0;
    req_ch.spi_fault = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ASSERT_TIMEOUT;
    cfg_ch.data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: store extremes, rejected starts, stray items
    do_load(7'd0, 8'hFF);
    do_load(7'd127, 8'h00);
    do_load(7'd1, 8'h00);
    do_load(7'd2, 8'hAA);
    do_load(7'd3, 8'h55);
    do_start(8'd255);
    do_start(8'd129);
    do_tick(1'b1);
    do_xchg(8'hFF, 1'b1);
    // empty frame aborted by a spi fault
    do_start(8'd0);
    do_tick(1'b0);
    do_tick(1'b1);
    do_xchg(8'h00, 1'b1);
    // empty frame with a bad peer magic
    do_start(8'd0);
    do_tick(1'b1);
    repeat (8) do_xchg(8'h00, 1'b0);
    do_tick(1'b0);

    random_traffic(ITEM_TARGET / 5);

    // lowest settings
    program_regs(16'd0, 16'd0, 8'd0);
    random_traffic(2 * ITEM_TARGET / 5);

    // highest timeouts and a capacity of MAX_PAYLOAD, with the long result hold-off
    program_regs(16'hFFFF, 16'hFFFF, 8'(MAX_PAYLOAD));
    hold_req = 1'b1;
    random_traffic(3 * ITEM_TARGET / 5);

    // short timeouts, with a full drain half way
    program_regs(16'd3, 16'd2, 8'd16);
    random_traffic(3 * ITEM_TARGET / 5 + ITEM_TARGET / 10);
    wait_drained();
    random_traffic(4 * ITEM_TARGET / 5);

    // random settings
    program_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                 8'($urandom_range(0, MAX_PAYLOAD)));
    random_traffic(ITEM_TARGET);

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sfh_pkg.sv
rtl/sfh_if.sv
rtl/sfh_tx_store.sv
rtl/sfh_core.sv
rtl/spi_frame_host_with_ready_handshake.sv
dv/tb_spi_frame_host_with_ready_handshake.sv
